// ===== design/heightmap_grid_mesh_generator_assert.svh =====
// Assertion macros used by the heightmap_grid_mesh_generator design file.
`ifndef HEIGHTMAP_GRID_MESH_GENERATOR_ASSERT_SVH
`define HEIGHTMAP_GRID_MESH_GENERATOR_ASSERT_SVH
`ifndef SYNTH
`define HGM_ASSERT_IMP(lbl, clk, rst, a, b) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("same-cycle check failed");
`define HGM_ASSERT_NEXT(lbl, clk, rst, a, b) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("next-cycle check failed");
`else
`define HGM_ASSERT_IMP(lbl, clk, rst, a, b)
`define HGM_ASSERT_NEXT(lbl, clk, rst, a, b)
`endif
`endif

// ===== design/hgm_pkg.sv =====
package hgm_pkg;

  localparam logic [1:0] REG_MAP_WIDTH  = 2'd0;
  localparam logic [1:0] REG_MAP_HEIGHT = 2'd1;
  localparam logic [1:0] REG_XZ_SCALE   = 2'd2;
  localparam logic [1:0] REG_Y_SCALE    = 2'd3;

  localparam logic [15:0] XZ_SCALE_RST = 16'd25600;
  localparam logic [15:0] Y_SCALE_RST  = 16'd2560;
  localparam int          DIM_RST      = 256;
  localparam int          DIM_MIN      = 2;

  // The average of three components is taken as (sum * 683) >> 11.
  localparam logic [19:0] AVG_RECIP = 20'd683;
  localparam int          AVG_SHIFT = 11;
  localparam logic [7:0]  HEIGHT_DIV = 8'd255;

  localparam int QUOT_BITS = 17;

  localparam logic [2:0] SEQ_VERTEX = 3'd0;
  localparam logic [2:0] SEQ_C      = 3'd1;
  localparam logic [2:0] SEQ_N      = 3'd2;
  localparam logic [2:0] SEQ_C1_A   = 3'd3;
  localparam logic [2:0] SEQ_C1_B   = 3'd4;
  localparam logic [2:0] SEQ_N_B    = 3'd5;
  localparam logic [2:0] SEQ_N1     = 3'd6;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV
  } hgm_state_t;

  typedef struct packed {
    logic [15:0] pos_x;
    logic [15:0] pos_y;
    logic [15:0] pos_z;
    logic [16:0] tex_u;
    logic [16:0] tex_v;
    logic [23:0] c_idx;
    logic [23:0] n_idx;
    logic        quad;
  } emit_load_t;

endpackage

// ===== design/heightmap_grid_mesh_generator.sv =====
// A vertex result appears after its pixel has passed the multiply state, the
// bit-serial dividers (one of 17 quotient bits per cycle) and the output stage.
// A new pixel is taken once the last one's results are loaded; the up to seven
// results of a pixel drain from the output stage as the next one is computed.
// Reset (synchronous, active high) zeroes the row and column counters and
// loads the default map size and scales.
`include "heightmap_grid_mesh_generator_assert.svh"

module heightmap_grid_mesh_generator import hgm_pkg::*; #(
  parameter int MAX_DIM = 4096
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        pixel_valid,
  output logic        pixel_stall,
  input  logic [7:0]  red,
  input  logic [7:0]  green,
  input  logic [7:0]  blue,
  output logic        result_valid,
  input  logic        result_stall,
  output logic        kind,
  output logic [15:0] pos_x,
  output logic [15:0] pos_y,
  output logic [15:0] pos_z,
  output logic [16:0] tex_u,
  output logic [16:0] tex_v,
  output logic [23:0] vertex_index,
  output logic        last
);

  localparam int CW      = (MAX_DIM > 2) ? $clog2(MAX_DIM) : 2;
  localparam int DW      = $clog2(MAX_DIM + 1);
  localparam int EW      = (DW > 13) ? DW : 13;
  localparam int RST_DIM = (DIM_RST > MAX_DIM) ? MAX_DIM : DIM_RST;
  localparam int NW      = CW + 16;

  hgm_state_t state, state_next;

  logic [DW-1:0] wdim;
  logic [CW-1:0] wm1;
  logic [CW-1:0] hm1;
  logic [15:0]   xz_scale;
  logic [15:0]   y_scale;
  logic [CW-1:0] column_count;
  logic [CW-1:0] row_count;

  logic [CW-1:0] col;
  logic [CW-1:0] row;
  logic [7:0]    avg;
  logic          quad;
  logic [23:0]   c_idx;

  logic [EW-1:0] raw_dim;
  logic [EW-1:0] clamp_dim;
  logic [CW-1:0] col_now;
  logic [CW-1:0] row_now;
  logic          last_col_now;
  logic          last_row_now;
  logic [9:0]    pix_sum;
  logic [19:0]   avg_prod;
  logic          accept;

  logic [NW-1:0]    prod_x;
  logic [NW-1:0]    prod_z;
  logic [NW-1:0]    prod_u;
  logic [NW-1:0]    prod_v;
  logic [23:0]      prod_y;
  logic [CW+DW-1:0] idx_full;

  logic                 div_start;
  logic                 x_busy, z_busy, u_busy, v_busy, y_busy;
  logic [QUOT_BITS-1:0] x_q, z_q, u_q, v_q, y_q;
  logic                 divs_agree;

  logic       emit_load;
  logic       emit_ready;
  emit_load_t emit_data;

  always_comb begin
    raw_dim = EW'(cfg_data[12:0]);
    if (raw_dim < EW'(DIM_MIN)) begin
      clamp_dim = EW'(DIM_MIN);
    end else if (raw_dim > EW'(MAX_DIM)) begin
      clamp_dim = EW'(MAX_DIM);
    end else begin
      clamp_dim = raw_dim;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wdim     <= DW'(RST_DIM);
      wm1      <= CW'(RST_DIM - 1);
      hm1      <= CW'(RST_DIM - 1);
      xz_scale <= XZ_SCALE_RST;
      y_scale  <= Y_SCALE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MAP_WIDTH: begin
          wdim <= DW'(clamp_dim);
          wm1  <= CW'(clamp_dim - EW'(1));
        end
        REG_MAP_HEIGHT: hm1 <= CW'(clamp_dim - EW'(1));
        REG_XZ_SCALE:   xz_scale <= cfg_data;
        REG_Y_SCALE:    y_scale <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    col_now      = (column_count < wm1) ? column_count : wm1;
    row_now      = (row_count < hm1) ? row_count : hm1;
    last_col_now = (col_now == wm1);
    last_row_now = (row_now == hm1);
    pix_sum      = {2'b00, red} + {2'b00, green} + {2'b00, blue};
    avg_prod     = {10'd0, pix_sum} * AVG_RECIP;
    accept       = pixel_valid && !pixel_stall;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
    end else if (accept) begin
      if (last_col_now) begin
        column_count <= '0;
        row_count    <= last_row_now ? '0 : row_now + CW'(1);
      end else begin
        column_count <= col_now + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      col  <= col_now;
      row  <= row_now;
      avg  <= avg_prod[AVG_SHIFT+7:AVG_SHIFT];
      quad <= !(last_col_now || last_row_now);
    end
    if (div_start) begin
      c_idx <= 24'(idx_full);
    end
  end

  always_comb begin
    prod_x   = {16'd0, col} * {{CW{1'b0}}, xz_scale};
    prod_z   = {16'd0, row} * {{CW{1'b0}}, xz_scale};
    prod_u   = {col, 16'd0};
    prod_v   = {row, 16'd0};
    prod_y   = {16'd0, avg} * {8'd0, y_scale};
    idx_full = {{DW{1'b0}}, row} * {{CW{1'b0}}, wdim} + (CW + DW)'(col);
  end

  hgm_divser #(.NW(NW), .DW(CW), .QW(QUOT_BITS)) u_div_x (
    .clk(clk), .rst(rst), .start(div_start), .dividend(prod_x), .divisor(wm1),
    .busy(x_busy), .quotient(x_q)
  );

  hgm_divser #(.NW(NW), .DW(CW), .QW(QUOT_BITS)) u_div_z (
    .clk(clk), .rst(rst), .start(div_start), .dividend(prod_z), .divisor(hm1),
    .busy(z_busy), .quotient(z_q)
  );

  hgm_divser #(.NW(NW), .DW(CW), .QW(QUOT_BITS)) u_div_u (
    .clk(clk), .rst(rst), .start(div_start), .dividend(prod_u), .divisor(wm1),
    .busy(u_busy), .quotient(u_q)
  );

  hgm_divser #(.NW(NW), .DW(CW), .QW(QUOT_BITS)) u_div_v (
    .clk(clk), .rst(rst), .start(div_start), .dividend(prod_v), .divisor(hm1),
    .busy(v_busy), .quotient(v_q)
  );

  hgm_divser #(.NW(24), .DW(8), .QW(QUOT_BITS)) u_div_y (
    .clk(clk), .rst(rst), .start(div_start), .dividend(prod_y),
    .divisor(HEIGHT_DIV), .busy(y_busy), .quotient(y_q)
  );

  always_comb begin
    divs_agree = (x_busy == z_busy) && (x_busy == u_busy) && (x_busy == v_busy) &&
                 (x_busy == y_busy);
  end

  always_comb begin
    emit_data.pos_x = x_q[15:0];
    emit_data.pos_y = y_q[15:0];
    emit_data.pos_z = z_q[15:0];
    emit_data.tex_u = u_q;
    emit_data.tex_v = v_q;
    emit_data.c_idx = c_idx;
    emit_data.n_idx = c_idx + 24'(wdim);
    emit_data.quad  = quad;
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (pixel_valid) state_next = ST_MUL;
      ST_MUL:  state_next = ST_DIV;
      ST_DIV:  if (!x_busy && emit_ready) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    pixel_stall = (state != ST_IDLE);
    div_start   = (state == ST_MUL);
    emit_load   = (state == ST_DIV) && !x_busy && emit_ready;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  hgm_emit u_emit (
    .clk(clk),
    .rst(rst),
    .load(emit_load),
    .load_data(emit_data),
    .ready(emit_ready),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .kind(kind),
    .pos_x(pos_x),
    .pos_y(pos_y),
    .pos_z(pos_z),
    .tex_u(tex_u),
    .tex_v(tex_v),
    .vertex_index(vertex_index),
    .last(last)
  );

  `HGM_ASSERT_IMP(a_div_lockstep, clk, rst, 1'b1, divs_agree)
  `HGM_ASSERT_IMP(a_load_when_free, clk, rst, emit_load, emit_ready)
  `HGM_ASSERT_NEXT(a_accept_to_mul, clk, rst, pixel_valid && !pixel_stall, state == ST_MUL)
  `HGM_ASSERT_IMP(a_div_end_state, clk, rst, $fell(x_busy), state == ST_DIV)

endmodule

// ===== design/hgm_divser.sv =====
module hgm_divser import hgm_pkg::*; #(
  parameter int NW = 28,
  parameter int DW = 12,
  parameter int QW = 17
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [NW-1:0] dividend,
  input  logic [DW-1:0] divisor,
  output logic          busy,
  output logic [QW-1:0] quotient
);

  localparam int CNW = $clog2(QW + 1);

  logic [DW-1:0]  rem;
  logic [DW-1:0]  dsr;
  logic [QW-1:0]  sh;
  logic [CNW-1:0] cnt;
  logic [DW:0]    trial;
  logic [DW:0]    diff;
  logic           ge;

  // The quotient is known to fit in QW bits, so the upper dividend bits
  // already form a partial remainder below the divisor.
  always_comb begin
    trial = {rem, sh[QW-1]};
    diff  = trial - {1'b0, dsr};
    ge    = !diff[DW];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= CNW'(QW);
    end else if (busy) begin
      cnt <= cnt - CNW'(1);
      if (cnt == CNW'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= DW'(dividend[NW-1:QW]);
      sh  <= dividend[QW-1:0];
      dsr <= divisor;
    end else if (busy) begin
      rem <= ge ? diff[DW-1:0] : trial[DW-1:0];
      sh  <= {sh[QW-2:0], ge};
    end
  end

  assign quotient = sh;

endmodule

// ===== design/hgm_emit.sv =====
module hgm_emit import hgm_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        load,
  input  emit_load_t  load_data,
  output logic        ready,
  output logic        result_valid,
  input  logic        result_stall,
  output logic        kind,
  output logic [15:0] pos_x,
  output logic [15:0] pos_y,
  output logic [15:0] pos_z,
  output logic [16:0] tex_u,
  output logic [16:0] tex_v,
  output logic [23:0] vertex_index,
  output logic        last
);

  emit_load_t  held;
  logic        active;
  logic [2:0]  step;
  logic        advance;
  logic        last_item;
  logic        sel_kind;
  logic [23:0] sel_index;

  always_comb begin
    sel_kind  = 1'b1;
    sel_index = '0;
    case (step)
      SEQ_VERTEX: sel_kind  = 1'b0;
      SEQ_C:      sel_index = held.c_idx;
      SEQ_N:      sel_index = held.n_idx;
      SEQ_C1_A:   sel_index = held.c_idx + 24'd1;
      SEQ_C1_B:   sel_index = held.c_idx + 24'd1;
      SEQ_N_B:    sel_index = held.n_idx;
      SEQ_N1:     sel_index = held.n_idx + 24'd1;
      default:    sel_index = '0;
    endcase
    last_item = ((step == SEQ_VERTEX) && !held.quad) || (step == SEQ_N1);
    advance   = active && (!result_valid || !result_stall);
  end

  assign ready = !active;

  always_ff @(posedge clk) begin
    if (rst) begin
      active       <= 1'b0;
      step         <= SEQ_VERTEX;
      result_valid <= 1'b0;
    end else begin
      if (advance) begin
        result_valid <= 1'b1;
        if (last_item) begin
          active <= 1'b0;
        end else begin
          step <= step + 3'd1;
        end
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
      if (load) begin
        active <= 1'b1;
        step   <= SEQ_VERTEX;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      held <= load_data;
    end
    if (advance) begin
      kind         <= sel_kind;
      pos_x        <= sel_kind ? 16'd0 : held.pos_x;
      pos_y        <= sel_kind ? 16'd0 : held.pos_y;
      pos_z        <= sel_kind ? 16'd0 : held.pos_z;
      tex_u        <= sel_kind ? 17'd0 : held.tex_u;
      tex_v        <= sel_kind ? 17'd0 : held.tex_v;
      vertex_index <= sel_index;
      last         <= last_item;
    end
  end

endmodule
